FILE: hw/rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the photon lag correlation block.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int TS_W     = 32;
    localparam int LAG_W    = 6;
    localparam int PERIOD_W = 48;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 64;

    // configuration register indexes
    localparam logic CFG_LAG_BINS = 1'b0;
    localparam logic CFG_PERIOD   = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DIV  = 10'b00_0000_0010,
        S_RES  = 10'b00_0000_0100,
        S_CRA  = 10'b00_0000_1000,
        S_CRB  = 10'b00_0001_0000,
        S_CMUL = 10'b00_0010_0000,
        S_CACC = 10'b00_0100_0000,
        S_CNTR = 10'b00_1000_0000,
        S_CNTW = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } plc_state_t;

endpackage

FILE: hw/rtl/photon_lag_correlation_top.sv
// ----------------------------------------------------------------------------
// photon_lag_correlation_top
// Single-lag photon count correlator over a tagged bin table in block RAM.
// ----------------------------------------------------------------------------
// Photons arrive as nondecreasing timestamps; each is binned as
// floor(timestamp*65536 / bin_period_q16), saturated to 32 bits. Per-bin
// counts live in a TABLE_DEPTH-entry RAM (tag + count) addressed by bin mod
// TABLE_DEPTH. When a later bin opens, the closing bin adds
// count(bin)*count(bin-lag) to a saturating 64-bit sum. A transfer with tlast
// closes the record: one result transfer carries the sum, the photon total
// and the last bin, then the table and counters clear. The close is skipped
// when the lag is zero or the closing bin is below the lag. One item at a
// time; saturated bins skip the restoring divider (one quotient bit per
// cycle). Valid bits sit in flops, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module photon_lag_correlation_top
    import plc_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // config write port
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // [31:0] timestamp
    input  logic                s_tlast,   // final_item
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [127:0]        m_tdata    // [63:0] pair_sum, [95:64] photon_total,
                                           // [127:96] last_bin
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] SAT_SLOT = IDX_W'(64'hFFFF_FFFF % TABLE_DEPTH);
    localparam int LAG_N = 1 << LAG_W;

    // configuration
    logic [LAG_W-1:0]    lag_reg;
    logic [PERIOD_W-1:0] period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_reg    <= LAG_W'(5);
            period_reg <= PERIOD_W'(65536);
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_LAG_BINS) begin
                lag_reg <= cfg_wdata[LAG_W-1:0];
            end else begin
                period_reg <= cfg_wdata;
            end
        end
    end

    // lag mod depth, constant table
    logic [IDX_W-1:0] lag_mod [LAG_N];
    for (genvar g = 0; g < LAG_N; g++) begin : g_lagmod
        assign lag_mod[g] = IDX_W'(g % TABLE_DEPTH);
    end

    // control and datapath registers
    plc_state_t          state_reg;
    logic                started_reg;
    logic                fin_reg;
    logic                closing_final_reg;
    logic [TS_W-1:0]     cur_reg;
    logic [IDX_W-1:0]    slot_cur_reg;
    logic [TS_W-1:0]     q_reg;        // bin being worked on
    logic [IDX_W-1:0]    slot_bin_reg; // q_reg mod depth
    logic [PERIOD_W-1:0] rem_reg;
    logic [31:0]         lo_reg;
    logic [4:0]          dcnt_reg;
    logic [CNT_W-1:0]    cnt_a_reg;
    logic [SUM_W-1:0]    prod_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    // bin table RAM: {tag, count}
    logic [TS_W+CNT_W-1:0] mem [TABLE_DEPTH];
    logic [TS_W+CNT_W-1:0] mem_rd_q;
    logic [IDX_W-1:0]      mem_ra;
    logic                  mem_we;
    logic [TS_W+CNT_W-1:0] mem_wd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[slot_bin_reg] <= mem_wd;
        end
        mem_rd_q <= mem[mem_ra];
    end

    wire [TS_W-1:0]  rd_tag = mem_rd_q[TS_W+CNT_W-1:CNT_W];
    wire [CNT_W-1:0] rd_cnt = mem_rd_q[CNT_W-1:0];

    // partner slot = (cur - lag) mod depth
    logic [IDX_W-1:0] lagm;
    logic [IDX_W-1:0] pslot;
    logic [TS_W-1:0]  partner_bin;
    assign lagm        = lag_mod[lag_reg];
    assign pslot       = (slot_cur_reg >= lagm) ? (slot_cur_reg - lagm)
                       : IDX_W'((IDX_W+1)'(slot_cur_reg) + (IDX_W+1)'(TABLE_DEPTH)
                                - (IDX_W+1)'(lagm));
    assign partner_bin = cur_reg - TS_W'(lag_reg);

    always_comb begin
        case (state_reg)
            S_CRA:   mem_ra = slot_cur_reg;
            S_CRB:   mem_ra = pslot;
            default: mem_ra = slot_bin_reg;
        endcase
    end

    // divider step: shift one dividend bit in, one quotient bit out
    logic [PERIOD_W:0]  div_trial;
    logic               div_ge;
    logic [IDX_W:0]     rm_trial;
    logic [IDX_W-1:0]   rm_next;
    assign div_trial = {rem_reg, lo_reg[31]};
    assign div_ge    = (div_trial >= {1'b0, period_reg});
    assign rm_trial  = {slot_bin_reg, div_ge};
    assign rm_next   = (rm_trial >= (IDX_W+1)'(TABLE_DEPTH))
                     ? IDX_W'(rm_trial - (IDX_W+1)'(TABLE_DEPTH)) : IDX_W'(rm_trial);

    // close skipped when lag is zero or current bin below lag
    logic close_skip;
    assign close_skip = (lag_reg == '0) || (cur_reg < TS_W'(lag_reg));

    // counting
    logic             cnt_hit;
    logic [CNT_W-1:0] cnt_new;
    assign cnt_hit = valid_reg[slot_bin_reg] && (rd_tag == q_reg);
    assign cnt_new = !cnt_hit ? CNT_W'(1) : (&rd_cnt) ? rd_cnt : rd_cnt + CNT_W'(1);
    assign mem_we  = (state_reg == S_CNTW);
    assign mem_wd  = {q_reg, cnt_new};

    logic [SUM_W:0] sum_add;
    assign sum_add = {1'b0, sum_reg} + {1'b0, prod_reg};

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            started_reg       <= 1'b0;
            closing_final_reg <= 1'b0;
            cur_reg           <= '0;
            slot_cur_reg      <= '0;
            sum_reg           <= '0;
            total_reg         <= '0;
            valid_reg         <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        fin_reg           <= s_tlast;
                        closing_final_reg <= 1'b0;
                        rem_reg           <= PERIOD_W'(s_tdata[31:16]);
                        lo_reg            <= {s_tdata[15:0], 16'h0};
                        dcnt_reg          <= '0;
                        if (PERIOD_W'(s_tdata[31:16]) >= period_reg) begin
                            q_reg        <= '1;   // quotient overflow or zero period
                            slot_bin_reg <= SAT_SLOT;
                            state_reg    <= S_RES;
                        end else begin
                            slot_bin_reg <= '0;
                            state_reg    <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    rem_reg      <= div_ge ? PERIOD_W'(div_trial - {1'b0, period_reg})
                                           : div_trial[PERIOD_W-1:0];
                    lo_reg       <= {lo_reg[30:0], 1'b0};
                    q_reg        <= {q_reg[30:0], div_ge};
                    slot_bin_reg <= rm_next;
                    dcnt_reg     <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd31) begin
                        state_reg <= S_RES;
                    end
                end
                S_RES: begin
                    if (!started_reg) begin
                        started_reg  <= 1'b1;
                        cur_reg      <= q_reg;
                        slot_cur_reg <= slot_bin_reg;
                        state_reg    <= S_CNTR;
                    end else if (q_reg <= cur_reg) begin
                        q_reg        <= cur_reg;  // merge into current bin
                        slot_bin_reg <= slot_cur_reg;
                        state_reg    <= S_CNTR;
                    end else if (close_skip) begin
                        cur_reg      <= q_reg;
                        slot_cur_reg <= slot_bin_reg;
                        state_reg    <= S_CNTR;
                    end else begin
                        state_reg <= S_CRA;
                    end
                end
                S_CRA: state_reg <= S_CRB;
                S_CRB: begin
                    cnt_a_reg <= (valid_reg[slot_cur_reg] && rd_tag == cur_reg) ? rd_cnt : '0;
                    state_reg <= S_CMUL;
                end
                S_CMUL: begin
                    prod_reg  <= (valid_reg[pslot] && rd_tag == partner_bin)
                               ? SUM_W'(cnt_a_reg) * SUM_W'(rd_cnt) : '0;
                    state_reg <= S_CACC;
                end
                S_CACC: begin
                    sum_reg <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    if (closing_final_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        cur_reg      <= q_reg;
                        slot_cur_reg <= slot_bin_reg;
                        state_reg    <= S_CNTR;
                    end
                end
                S_CNTR: state_reg <= S_CNTW;
                S_CNTW: begin
                    valid_reg[slot_bin_reg] <= 1'b1;
                    if (!(&total_reg)) begin
                        total_reg <= total_reg + CNT_W'(1);
                    end
                    if (!fin_reg) begin
                        state_reg <= S_IDLE;
                    end else begin
                        closing_final_reg <= 1'b1;
                        state_reg         <= close_skip ? S_OUT : S_CRA;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        started_reg <= 1'b0;
                        cur_reg     <= '0;
                        sum_reg     <= '0;
                        total_reg   <= '0;
                        valid_reg   <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {cur_reg, total_reg, sum_reg};

endmodule

FILE: hw/rtl/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks for the photon lag correlation block.
// ----------------------------------------------------------------------------
module plc_checker
    import plc_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no intake while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // an accepted item keeps the block busy next cycle
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("block idle right after accepting an item");

    // a delivered result is not repeated
    a_single_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result repeated");

    // reset leaves no result pending
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind photon_lag_correlation_top plc_checker u_plc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
